@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/hdu_pkg.sv @@
// Types and constants of the half-duplex UART
package hdu_pkg;
	localparam int FUNC_W = 2;
	localparam int DATA_W = 8;
	localparam int CPB_W = 16;
	localparam int BAUD_W = 17;
	localparam int FRAME_W = 10;
	localparam int BITCNT_W = 4;

	localparam int TX_DEPTH_DEF = 16;
	localparam int RX_DEPTH_DEF = 16;

	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

	localparam logic [CPB_W-1:0] CPB_RESET = 16'd104;
	localparam logic [CPB_W-1:0] MIN_PERIOD = 16'd4;
	localparam logic [BITCNT_W-1:0] FRAME_BITS = 4'd10;
	localparam logic [BITCNT_W-1:0] BYTE_BITS = 4'd8;
	localparam logic [FRAME_W-1:0] SHIFT_IDLE = 10'h3FF;
	localparam logic [FRAME_W-1:0] SHIFT_START = 10'h200;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_TX = 2'd1,
		MODE_RX = 2'd2
	} mode_t;

	typedef struct packed {
		logic tx_line;
		logic tx_drive;
		logic read_valid;
		logic write_accepted;
		logic tx_pending;
		logic rx_pending;
		logic rx_overflow;
		mode_t link_mode;
	} res_t;
endpackage

@@ rtl/core/hdu_in_if.sv @@
// Input item channel: one line tick with an optional host access
interface hdu_in_if import hdu_pkg::*; ();
	logic valid;
	logic ready;
	logic [FUNC_W-1:0] func;
	logic rx_line;
	logic [DATA_W-1:0] write_data;

	modport source(output valid, func, rx_line, write_data, input ready);
	modport sink(input valid, func, rx_line, write_data, output ready);
endinterface

@@ rtl/core/hdu_out_if.sv @@
// Result item channel: line drive, host access result and status
interface hdu_out_if import hdu_pkg::*; ();
	logic valid;
	logic ready;
	logic tx_line;
	logic tx_drive;
	logic [DATA_W-1:0] read_data;
	logic read_valid;
	logic write_accepted;
	logic tx_pending;
	logic rx_pending;
	logic rx_overflow;
	logic [1:0] link_mode;

	modport source(output valid, tx_line, tx_drive, read_data, read_valid, write_accepted,
		tx_pending, rx_pending, rx_overflow, link_mode, input ready);
	modport sink(input valid, tx_line, tx_drive, read_data, read_valid, write_accepted,
		tx_pending, rx_pending, rx_overflow, link_mode, output ready);
endinterface

@@ rtl/core/half_duplex_uart_with_fifos_top.sv @@
// A result leaves through the stage-1 register (with the RAM read) and then the output register.
// Throughput: one item per cycle unless item_out.ready stalls the output; the output register and
// the stage before it decouple the sides, and the receive FIFO read data is registered with stage 1.
// Reset (arst_n, asynchronous): pointers, mode, counters and flags clear, the line
// shifter goes to all ones, the bit period returns to 104; FIFO storage is not cleared.
`include "assert_macros.svh"

module half_duplex_uart_with_fifos_top import hdu_pkg::*; #(
	parameter int TX_DEPTH = TX_DEPTH_DEF,
	parameter int RX_DEPTH = RX_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CPB_W-1:0] cfg_wr_data,
	hdu_in_if.sink item_in,
	hdu_out_if.source item_out
);
	localparam int TAW = $clog2(TX_DEPTH);
	localparam int RAW = $clog2(RX_DEPTH);
	localparam logic [TAW-1:0] TX_LAST = TAW'(TX_DEPTH - 1);
	localparam logic [RAW-1:0] RX_LAST = RAW'(RX_DEPTH - 1);

	logic [CPB_W-1:0] cpb_q;
	logic [TAW-1:0] tx_wr_ptr_q, tx_rd_ptr_q, tx_wr_d, tx_rd_d, tx_wr_nxt, tx_rd_nxt;
	logic [RAW-1:0] rx_wr_ptr_q, rx_rd_ptr_q, rx_wr_d, rx_rd_d, rx_wr_nxt, rx_rd_nxt;
	mode_t mode_q, mode_d;
	logic [FRAME_W-1:0] shift_q, shift_d;
	logic [BITCNT_W-1:0] bit_cnt_q, bit_cnt_d, bit_inc;
	logic [BAUD_W-1:0] baud_q, baud_d, baud_inc, limit;
	logic prev_line_q;
	logic ovf_q, ovf_d;
	logic tx_fetch_q, tx_fwd_q;
	logic [DATA_W-1:0] tx_fwd_data_q, tx_rdata, rx_rdata, fetch_byte;

	logic [CPB_W-1:0] period;
	logic acc, fall_det;
	logic tx_we, rx_re, tx_start, rx_store;

	logic valid_s1, valid_s2, adv_s1;
	res_t res_d, res_s1, res_s2;
	logic [DATA_W-1:0] read_data_s2;

	assign adv_s1 = valid_s1 && (!valid_s2 || item_out.ready);
	assign item_in.ready = !valid_s1 || adv_s1;
	assign acc = item_in.valid && item_in.ready;

	assign period = (cpb_q < MIN_PERIOD) ? MIN_PERIOD : cpb_q;
	assign fall_det = prev_line_q && !item_in.rx_line;
	assign fetch_byte = tx_fwd_q ? tx_fwd_data_q : tx_rdata;

	assign tx_wr_nxt = (tx_wr_ptr_q == TX_LAST) ? '0 : tx_wr_ptr_q + 1'b1;
	assign tx_rd_nxt = (tx_rd_ptr_q == TX_LAST) ? '0 : tx_rd_ptr_q + 1'b1;
	assign rx_wr_nxt = (rx_wr_ptr_q == RX_LAST) ? '0 : rx_wr_ptr_q + 1'b1;
	assign rx_rd_nxt = (rx_rd_ptr_q == RX_LAST) ? '0 : rx_rd_ptr_q + 1'b1;

	assign tx_we = acc && (item_in.func == FUNC_WRITE) && (tx_wr_nxt != tx_rd_ptr_q);
	assign rx_re = acc && (item_in.func == FUNC_READ) && (rx_rd_ptr_q != rx_wr_ptr_q);
	assign tx_wr_d = tx_we ? tx_wr_nxt : tx_wr_ptr_q;
	assign rx_rd_d = rx_re ? rx_rd_nxt : rx_rd_ptr_q;

	assign baud_inc = baud_q + 1'b1;
	assign bit_inc = bit_cnt_q + 1'b1;
	assign limit = (bit_cnt_q == '0) ? ({1'b0, period} + {2'b00, period[CPB_W-1:1]})
		: {1'b0, period};

	// next state of the line logic
	always_comb begin
		mode_d = mode_q;
		shift_d = shift_q;
		bit_cnt_d = bit_cnt_q;
		baud_d = baud_q;
		ovf_d = ovf_q;
		tx_rd_d = tx_rd_ptr_q;
		rx_wr_d = rx_wr_ptr_q;
		tx_start = 1'b0;
		rx_store = 1'b0;
		case (mode_q)
			MODE_TX: begin
				baud_d = baud_inc;
				if (baud_inc >= {1'b0, period}) begin
					baud_d = '0;
					shift_d = {1'b1, shift_q[FRAME_W-1:1]};
					bit_cnt_d = bit_inc;
					if (bit_inc >= FRAME_BITS) begin
						bit_cnt_d = '0;
						if (tx_rd_ptr_q != tx_wr_d) begin
							tx_start = 1'b1;
							tx_rd_d = tx_rd_nxt;
							shift_d = SHIFT_START;
						end else begin
							mode_d = MODE_IDLE;
							shift_d = SHIFT_IDLE;
						end
					end
				end
			end
			MODE_RX: begin
				baud_d = baud_inc;
				if (baud_inc >= limit) begin
					baud_d = '0;
					shift_d = {2'b11, item_in.rx_line, shift_q[DATA_W-1:1]};
					bit_cnt_d = bit_inc;
					if (bit_inc >= BYTE_BITS) begin
						if (rx_wr_nxt == rx_rd_d) begin
							ovf_d = 1'b1;
						end else begin
							rx_store = 1'b1;
							rx_wr_d = rx_wr_nxt;
						end
						mode_d = MODE_IDLE;
						shift_d = SHIFT_IDLE;
						bit_cnt_d = '0;
					end
				end
			end
			default: begin
				mode_d = MODE_IDLE;
				if (fall_det) begin
					mode_d = MODE_RX;
					shift_d = SHIFT_IDLE;
					bit_cnt_d = '0;
					baud_d = '0;
				end else if (tx_rd_ptr_q != tx_wr_d) begin
					tx_start = 1'b1;
					tx_rd_d = tx_rd_nxt;
					mode_d = MODE_TX;
					shift_d = SHIFT_START;
					bit_cnt_d = '0;
					baud_d = '0;
				end
			end
		endcase
	end

	// result of the item
	always_comb begin
		res_d.tx_line = (mode_d == MODE_TX) ? shift_d[0] : 1'b1;
		res_d.tx_drive = (mode_d == MODE_TX);
		res_d.read_valid = rx_re;
		res_d.write_accepted = tx_we;
		res_d.tx_pending = (tx_rd_d != tx_wr_d);
		res_d.rx_pending = (rx_rd_d != rx_wr_d);
		res_d.rx_overflow = ovf_d;
		res_d.link_mode = mode_d;
	end

	hdu_ram #(.WIDTH(DATA_W), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk(clk),
		.we(tx_we),
		.waddr(tx_wr_ptr_q),
		.wdata(item_in.write_data),
		.re(acc && tx_start),
		.raddr(tx_rd_ptr_q),
		.rdata(tx_rdata)
	);

	hdu_ram #(.WIDTH(DATA_W), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk(clk),
		.we(acc && rx_store),
		.waddr(rx_wr_ptr_q),
		.wdata(shift_d[DATA_W-1:0]),
		.re(rx_re),
		.raddr(rx_rd_ptr_q),
		.rdata(rx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpb_q <= CPB_RESET;
			tx_wr_ptr_q <= '0;
			tx_rd_ptr_q <= '0;
			rx_wr_ptr_q <= '0;
			rx_rd_ptr_q <= '0;
			mode_q <= MODE_IDLE;
			shift_q <= SHIFT_IDLE;
			bit_cnt_q <= '0;
			baud_q <= '0;
			prev_line_q <= 1'b1;
			ovf_q <= 1'b0;
			tx_fetch_q <= 1'b0;
			tx_fwd_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cpb_q <= cfg_wr_data;
			end
			if (acc) begin
				tx_wr_ptr_q <= tx_wr_d;
				tx_rd_ptr_q <= tx_rd_d;
				rx_wr_ptr_q <= rx_wr_d;
				rx_rd_ptr_q <= rx_rd_d;
				mode_q <= mode_d;
				bit_cnt_q <= bit_cnt_d;
				baud_q <= baud_d;
				prev_line_q <= item_in.rx_line;
				ovf_q <= ovf_d;
			end
			// merge the fetched byte into the frame in the cycle after the start
			if (acc) begin
				shift_q <= tx_fetch_q ? {shift_d[FRAME_W-1], fetch_byte, shift_d[0]} : shift_d;
			end else if (tx_fetch_q) begin
				shift_q[DATA_W:1] <= fetch_byte;
			end
			tx_fetch_q <= acc && tx_start;
			tx_fwd_q <= acc && tx_start && tx_we && (tx_wr_ptr_q == tx_rd_ptr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_in.ready) begin
				valid_s1 <= acc;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (item_out.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tx_fwd_data_q <= item_in.write_data;
			res_s1 <= res_d;
		end
		if (adv_s1) begin
			res_s2 <= res_s1;
			read_data_s2 <= res_s1.read_valid ? rx_rdata : '0;
		end
	end

	assign item_out.valid = valid_s2;
	assign item_out.tx_line = res_s2.tx_line;
	assign item_out.tx_drive = res_s2.tx_drive;
	assign item_out.read_data = read_data_s2;
	assign item_out.read_valid = res_s2.read_valid;
	assign item_out.write_accepted = res_s2.write_accepted;
	assign item_out.tx_pending = res_s2.tx_pending;
	assign item_out.rx_pending = res_s2.rx_pending;
	assign item_out.rx_overflow = res_s2.rx_overflow;
	assign item_out.link_mode = res_s2.link_mode;

	`ASSERT_IMPLIES(a_fetch_at_frame_start, clk, arst_n, tx_fetch_q,
		mode_q == MODE_TX && baud_q == '0 && bit_cnt_q == '0)
	`ASSERT_IMPLIES(a_rx_bit_range, clk, arst_n, mode_q == MODE_RX, bit_cnt_q < BYTE_BITS)
	`ASSERT_IMPLIES(a_idle_clean, clk, arst_n, mode_q == MODE_IDLE,
		shift_q == SHIFT_IDLE && bit_cnt_q == '0 && baud_q == '0)
	`ASSERT_NEXT(a_stage1_holds, clk, arst_n, valid_s1 && !adv_s1, valid_s1 && $stable(res_s1))
endmodule

@@ rtl/core/hdu_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module hdu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ verif/hdu_uart_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the half-duplex UART: predicts each tick's result and compares it

module hdu_uart_checker import hdu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CPB_W-1:0] cfg_wr_data,
	hdu_in_if in_ch,
	hdu_out_if out_ch,
	output int fail_count,
	output int pending_count
);
	typedef struct packed {
		logic tx_line;
		logic tx_drive;
		logic [DATA_W-1:0] read_data;
		logic read_valid;
		logic write_accepted;
		logic tx_pending;
		logic rx_pending;
		logic rx_overflow;
		mode_t link_mode;
	} tick_result_t;

	logic [CPB_W-1:0] bit_period;
	logic [DATA_W-1:0] tx_mem [TX_DEPTH_DEF];
	logic [DATA_W-1:0] rx_mem [RX_DEPTH_DEF];
	int tx_wr;
	int tx_rd;
	int rx_wr;
	int rx_rd;
	mode_t mode;
	logic [FRAME_W-1:0] shifter;
	logic [BITCNT_W-1:0] bits_done;
	logic [BAUD_W-1:0] baud;
	logic last_line;
	logic overflowed;
	tick_result_t predicted_ticks [$];
	tick_result_t want;
	int mismatches = 0;
	int results_seen = 0;

	function automatic int next_slot(int p, int depth);
		return (p + 1 >= depth) ? 0 : p + 1;
	endfunction

	function automatic void enter_idle();
		mode = MODE_IDLE;
		shifter = SHIFT_IDLE;
		bits_done = '0;
		baud = '0;
	endfunction

	function automatic void load_frame();
		shifter = SHIFT_START | {1'b0, tx_mem[tx_rd], 1'b0};
		tx_rd = next_slot(tx_rd, TX_DEPTH_DEF);
		mode = MODE_TX;
		bits_done = '0;
		baud = '0;
	endfunction

	function automatic tick_result_t predict_tick(logic [FUNC_W-1:0] f, logic line,
			logic [DATA_W-1:0] wd);
		tick_result_t r;
		logic [BAUD_W-1:0] per;
		logic [BAUD_W-1:0] limit;
		logic fall;
		int slot;
		r = '0;
		per = (bit_period < MIN_PERIOD) ? BAUD_W'(MIN_PERIOD) : BAUD_W'(bit_period);
		fall = last_line && !line;
		if (f == FUNC_WRITE) begin
			slot = next_slot(tx_wr, TX_DEPTH_DEF);
			if (slot != tx_rd) begin
				tx_mem[tx_wr] = wd;
				tx_wr = slot;
				r.write_accepted = 1'b1;
			end
		end else if (f == FUNC_READ) begin
			if (rx_rd != rx_wr) begin
				r.read_data = rx_mem[rx_rd];
				rx_rd = next_slot(rx_rd, RX_DEPTH_DEF);
				r.read_valid = 1'b1;
			end
		end
		case (mode)
			MODE_TX: begin
				baud = baud + 1'b1;
				if (baud >= per) begin
					baud = '0;
					shifter = {1'b1, shifter[FRAME_W-1:1]};
					bits_done = bits_done + 1'b1;
					if (bits_done >= FRAME_BITS) begin
						if (tx_rd != tx_wr) begin
							load_frame();
						end else begin
							enter_idle();
						end
					end
				end
			end
			MODE_RX: begin
				limit = (bits_done == '0) ? per + (per >> 1) : per;
				baud = baud + 1'b1;
				if (baud >= limit) begin
					baud = '0;
					shifter = {2'b11, line, shifter[7:1]};
					bits_done = bits_done + 1'b1;
					if (bits_done >= BYTE_BITS) begin
						slot = next_slot(rx_wr, RX_DEPTH_DEF);
						if (slot == rx_rd) begin
							overflowed = 1'b1;
						end else begin
							rx_mem[rx_wr] = shifter[DATA_W-1:0];
							rx_wr = slot;
						end
						enter_idle();
					end
				end
			end
			default: begin
				mode = MODE_IDLE;
				if (fall) begin
					mode = MODE_RX;
					shifter = SHIFT_IDLE;
					bits_done = '0;
					baud = '0;
				end else if (tx_rd != tx_wr) begin
					load_frame();
				end
			end
		endcase
		last_line = line;
		r.tx_line = (mode == MODE_TX) ? shifter[0] : 1'b1;
		r.tx_drive = (mode == MODE_TX);
		r.tx_pending = (tx_rd != tx_wr);
		r.rx_pending = (rx_rd != rx_wr);
		r.rx_overflow = overflowed;
		r.link_mode = mode;
		return r;
	endfunction

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] exp_v);
		if (got !== exp_v) begin
			report($sformatf("result %0d %s: got %0h, expected %0h", results_seen, name,
				got, exp_v));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period = CPB_RESET;
			tx_wr = 0;
			tx_rd = 0;
			rx_wr = 0;
			rx_rd = 0;
			last_line = 1'b1;
			overflowed = 1'b0;
			enter_idle();
			predicted_ticks.delete();
			pending_count <= 0;
			fail_count <= mismatches;
		end else begin
			if (cfg_wr_en) begin
				bit_period = cfg_wr_data;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (predicted_ticks.size() == 0) begin
					report($sformatf("result %0d arrived with no item outstanding",
						results_seen));
				end else begin
					want = predicted_ticks.pop_front();
					check_field("tx_line", DATA_W'(out_ch.tx_line), DATA_W'(want.tx_line));
					check_field("tx_drive", DATA_W'(out_ch.tx_drive), DATA_W'(want.tx_drive));
					check_field("read_data", out_ch.read_data, want.read_data);
					check_field("read_valid", DATA_W'(out_ch.read_valid),
						DATA_W'(want.read_valid));
					check_field("write_accepted", DATA_W'(out_ch.write_accepted),
						DATA_W'(want.write_accepted));
					check_field("tx_pending", DATA_W'(out_ch.tx_pending),
						DATA_W'(want.tx_pending));
					check_field("rx_pending", DATA_W'(out_ch.rx_pending),
						DATA_W'(want.rx_pending));
					check_field("rx_overflow", DATA_W'(out_ch.rx_overflow),
						DATA_W'(want.rx_overflow));
					check_field("link_mode", DATA_W'(out_ch.link_mode),
						DATA_W'(want.link_mode));
				end
				results_seen++;
			end
			if (in_ch.valid && in_ch.ready) begin
				predicted_ticks.push_back(predict_tick(in_ch.func, in_ch.rx_line,
					in_ch.write_data));
			end
			pending_count <= predicted_ticks.size();
			fail_count <= mismatches;
		end
	end
endmodule

@@ verif/tb_half_duplex_uart_with_fifos_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the half-duplex UART: clock, reset, line and host stimulus, verdict

module tb_half_duplex_uart_with_fifos_top;
	import hdu_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 400;
	localparam int SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CPB_W-1:0] cfg_wr_data;
	logic [CPB_W-1:0] bit_period;
	bit idling_on = 1'b1;
	int quiet_cycles = 0;
	int items_sent = 0;
	int fail_count;
	int pending_count;
	logic [CPB_W-1:0] phase_periods [8] = '{16'd4, 16'd5, 16'd0, 16'd8, 16'hFFFF, 16'd3,
		16'd6, 16'd4};

	hdu_in_if item_in();
	hdu_out_if item_out();

	half_duplex_uart_with_fifos_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_in(item_in),
		.item_out(item_out)
	);

	hdu_uart_checker uart_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch(item_in),
		.out_ch(item_out),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_in.valid && item_in.ready) || (item_out.valid && item_out.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		item_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (idling_on && $urandom_range(0, 9) == 0) begin
				item_out.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			item_out.ready <= 1'b1;
		end
	end

	function automatic logic [FUNC_W-1:0] pick_func(int write_pct, int read_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < write_pct) return FUNC_WRITE;
		if (roll < write_pct + read_pct) return FUNC_READ;
		if (roll < write_pct + read_pct + 3) return FUNC_UNUSED;
		return FUNC_NONE;
	endfunction

	function automatic int line_period();
		return (bit_period < MIN_PERIOD) ? int'(MIN_PERIOD) : int'(bit_period);
	endfunction

	task automatic send_tick(input logic [FUNC_W-1:0] f, input logic line,
			input logic [DATA_W-1:0] wd);
		if (idling_on && $urandom_range(0, 11) == 0) begin
			item_in.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		item_in.valid <= 1'b1;
		item_in.func <= f;
		item_in.rx_line <= line;
		item_in.write_data <= wd;
		do @(posedge clk); while (item_in.ready !== 1'b1);
		items_sent++;
	endtask

	task automatic send_frame(input logic [DATA_W-1:0] value, input int per,
			input logic [FUNC_W-1:0] first_func, input int write_pct, input int read_pct);
		logic [FRAME_W-1:0] frame;
		frame = {1'b1, value, 1'b0};
		for (int i = 0; i < FRAME_W; i++) begin
			for (int j = 0; j < per; j++) begin
				send_tick((i == 0 && j == 0) ? first_func : pick_func(write_pct, read_pct),
					frame[i], DATA_W'($urandom));
			end
		end
	endtask

	task automatic run_mix(input int count);
		int stop_at;
		int per;
		int kind;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			kind = $urandom_range(0, 9);
			per = line_period();
			if (kind < 5 && per <= 16) begin
				if ($urandom_range(0, 9) == 0) begin
					per = per + int'($urandom_range(0, 2)) - 1;
				end
				send_frame(DATA_W'($urandom), per,
					($urandom_range(0, 7) == 0) ? FUNC_WRITE : FUNC_NONE, 1, 2);
			end else if (kind < 7) begin
				repeat ($urandom_range(1, 12)) begin
					send_tick(pick_func(1, 5), 1'($urandom), DATA_W'($urandom));
				end
			end else if (kind < 9) begin
				repeat ($urandom_range(1, 10)) begin
					send_tick(pick_func(3, 15), 1'b1, DATA_W'($urandom));
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					send_tick(pick_func(15, 60), 1'b1, DATA_W'($urandom));
				end
			end
		end
	endtask

	task automatic set_period(input logic [CPB_W-1:0] value);
		// hold valid low until every result is back
		item_in.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		bit_period = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		bit_period = CPB_RESET;
		item_in.valid <= 1'b0;
		item_in.func <= FUNC_NONE;
		item_in.rx_line <= 1'b1;
		item_in.write_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_period(MIN_PERIOD);
		send_tick(FUNC_READ, 1'b1, 8'h00);
		send_tick(FUNC_UNUSED, 1'b1, 8'hFF);
		send_tick(FUNC_NONE, 1'b1, 8'h00);
		send_frame(8'hFF, line_period(), FUNC_WRITE, 0, 0);
		send_tick(FUNC_READ, 1'b1, 8'h00);
		send_tick(FUNC_WRITE, 1'b1, 8'h00);
		send_tick(FUNC_WRITE, 1'b1, 8'hFF);
		send_frame(8'h00, line_period(), FUNC_READ, 0, 0);

		foreach (phase_periods[p]) begin
			set_period(phase_periods[p]);
			run_mix(12);
		end

		set_period(MIN_PERIOD);
		repeat (17) send_tick(FUNC_READ, 1'b1, 8'h00);

		idling_on = 1'b0;
		repeat (18) send_tick(FUNC_WRITE, 1'b1, DATA_W'($urandom));
		repeat (12) send_tick(pick_func(0, 30), 1'($urandom), DATA_W'($urandom));

		item_in.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
